/* rtl/core/uart_framed_delta_sigma_modulator_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the uart framed delta-sigma modulator
// Shared concurrent assertion forms, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef UART_FRAMED_DELTA_SIGMA_MODULATOR_TOP_MACROS_SVH
`define UART_FRAMED_DELTA_SIGMA_MODULATOR_TOP_MACROS_SVH

// same-cycle implication
`define UFDSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion violated");

// next-cycle implication
`define UFDSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion violated");

`endif

/* rtl/core/ufdsm_pkg.sv */
// ----------------------------------------------------------------------------
// ufdsm_pkg
// Constants and widths shared by the uart framed delta-sigma modulator.
// ----------------------------------------------------------------------------
package ufdsm_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = 20;
    localparam int PHASE_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 4;

    // default fraction bits of the phase accumulator
    localparam int PHASE_FRAC_BITS_DEF = 31;

    // configuration reset value
    localparam logic [PHASE_W-1:0] PHASE_INC_RESET = 32'h8000_0000;

    // frame positions
    localparam logic [POS_W-1:0] POS_START = 4'd0;
    localparam logic [POS_W-1:0] POS_STOP  = 4'd9;

    // quantizer levels and error limits, in the wide error format
    localparam int ERR_CALC_W = 22;
    localparam logic signed [ERR_CALC_W-1:0] LEVEL_HIGH = 22'sd32767;
    localparam logic signed [ERR_CALC_W-1:0] LEVEL_LOW  = -22'sd32768;
    localparam logic signed [ERR_CALC_W-1:0] ERR_MAX    = 22'sd524287;
    localparam logic signed [ERR_CALC_W-1:0] ERR_MIN    = -22'sd524288;

endpackage

/* rtl/core/uart_framed_delta_sigma_modulator_top.sv */
// ----------------------------------------------------------------------------
// uart_framed_delta_sigma_modulator_top
// One-bit error-feedback modulator emitting line levels in 10-bit uart frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): one beat per serial bit time,
//   carrying the sample pending at the source. o_sample_taken in the matching
//   result tells the source to advance to its next sample.
//   Output channel (o_out_valid / i_out_ready): one beat per input beat, in
//   order: line level, sample-taken flag, and at the stop bit the byte.
//   Config channel (i_cfg_valid / o_cfg_ready): writes phase_increment, always
//   ready; write only while no beat is in flight.
// Timing:
//   an accepted beat lands in the input register; once the result register
//   is free, the accumulator, quantizer and frame counter update from it and
//   fill the result register. One beat per cycle sustained while the receiver
//   does not stall, set by the single add, subtract and saturate path
//   between the two registers.
// Reset and stall:
//   reset empties both registers and returns the accumulator to its
//   load-forcing value, error, frame position and byte to zero, and the
//   increment to 0x80000000. A stalled receiver holds the result register;
//   the input register still takes one more beat, then o_in_ready drops.
// ----------------------------------------------------------------------------
module uart_framed_delta_sigma_modulator_top #(
    parameter int PHASE_FRAC_BITS = ufdsm_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input beats
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [ufdsm_pkg::SAMPLE_W-1:0] i_next_sample,
    // result beats
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_line_level,
    output logic                                  o_sample_taken,
    output logic                                  o_byte_valid,
    output logic [ufdsm_pkg::BYTE_W-1:0]          o_byte_value,
    // configuration
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ufdsm_pkg::PHASE_W-1:0]         i_cfg_phase_increment
);

    localparam int PW = ufdsm_pkg::PHASE_W;
    localparam int SW = ufdsm_pkg::SAMPLE_W;
    localparam int EW = ufdsm_pkg::ERR_W;
    localparam int CW = ufdsm_pkg::ERR_CALC_W;
    localparam int BW = ufdsm_pkg::BYTE_W;
    localparam int QW = ufdsm_pkg::POS_W;
    localparam logic [PW-1:0] IntBit   = PW'(1) << PHASE_FRAC_BITS;
    localparam logic [PW-1:0] FracMask = IntBit - PW'(1);

    // control and payload registers
    logic                 r_in_valid;
    logic signed [SW-1:0] r_in_sample;
    logic                 r_out_valid;
    logic                 r_out_level;
    logic                 r_out_taken;
    logic                 r_out_byte_valid;
    logic [BW-1:0]        r_out_byte;

    // modulator state
    logic [PW-1:0]        r_phase_inc;
    logic [PW-1:0]        r_phase_acc;
    logic signed [SW-1:0] r_held;
    logic signed [EW-1:0] r_err;
    logic [QW-1:0]        r_pos;
    logic [BW-1:0]        r_shift;

    // next values
    logic [PW-1:0]        n_phase_acc;
    logic signed [SW-1:0] n_held;
    logic signed [EW-1:0] n_err;
    logic [QW-1:0]        n_pos;
    logic [BW-1:0]        n_shift;
    logic                 n_level;
    logic                 n_byte_valid;
    logic [BW-1:0]        n_byte;

    logic                 advance;
    logic                 proc;
    logic                 take;
    logic signed [CW-1:0] expected;
    logic signed [CW-1:0] err_raw;

    // handshake: the result register frees when empty or being taken
    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign proc        = r_in_valid && advance;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_sample <= i_next_sample;
        end
    end

    // sample latch and phase step
    always_comb begin
        take        = r_phase_acc[PHASE_FRAC_BITS];
        n_held      = take ? r_in_sample : r_held;
        n_phase_acc = (r_phase_acc & FracMask) + r_phase_inc;
        expected    = CW'(n_held) - CW'(r_err);
    end

    // frame sequencing and quantizer decision
    always_comb begin
        n_byte_valid = 1'b0;
        n_byte       = '0;
        n_shift      = r_shift;
        priority if (r_pos == ufdsm_pkg::POS_START) begin
            n_level = 1'b0;
            n_shift = '0;
            n_pos   = QW'(1);
        end else if (r_pos >= ufdsm_pkg::POS_STOP) begin
            n_level      = 1'b1;
            n_byte_valid = 1'b1;
            n_byte       = r_shift;
            n_pos        = ufdsm_pkg::POS_START;
        end else begin
            n_level = !expected[CW-1];
            n_shift = {n_level, r_shift[BW-1:1]};
            n_pos   = r_pos + QW'(1);
        end
    end

    // error feedback with saturation
    always_comb begin
        err_raw = (n_level ? ufdsm_pkg::LEVEL_HIGH : ufdsm_pkg::LEVEL_LOW) - expected;
        priority if (err_raw > ufdsm_pkg::ERR_MAX) begin
            n_err = EW'(ufdsm_pkg::ERR_MAX);
        end else if (err_raw < ufdsm_pkg::ERR_MIN) begin
            n_err = EW'(ufdsm_pkg::ERR_MIN);
        end else begin
            n_err = EW'(err_raw);
        end
    end

    // state registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= ufdsm_pkg::PHASE_INC_RESET;
            r_phase_acc <= IntBit;
            r_held      <= '0;
            r_err       <= '0;
            r_pos       <= ufdsm_pkg::POS_START;
            r_shift     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_phase_inc <= i_cfg_phase_increment;
            end
            if (proc) begin
                r_phase_acc <= n_phase_acc;
                r_held      <= n_held;
                r_err       <= n_err;
                r_pos       <= n_pos;
                r_shift     <= n_shift;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (proc) begin
            r_out_level      <= n_level;
            r_out_taken      <= take;
            r_out_byte_valid <= n_byte_valid;
            r_out_byte       <= n_byte;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_line_level   = r_out_level;
    assign o_sample_taken = r_out_taken;
    assign o_byte_valid   = r_out_byte_valid;
    assign o_byte_value   = r_out_byte;

endmodule

/* rtl/core/ufdsm_checker.sv */
// ----------------------------------------------------------------------------
// ufdsm_checker
// Port-level checks on the uart framed delta-sigma modulator, bound to top.
// ----------------------------------------------------------------------------
`include "uart_framed_delta_sigma_modulator_top_macros.svh"

module ufdsm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic                         o_line_level,
    input logic                         o_sample_taken,
    input logic                         o_byte_valid,
    input logic [ufdsm_pkg::BYTE_W-1:0] o_byte_value
);

    logic                         out_stall;
    logic [ufdsm_pkg::BYTE_W+2:0] out_beat;

    // stalled result beat and its payload
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_beat  = {o_line_level, o_sample_taken, o_byte_valid, o_byte_value};

    // a stalled result beat holds
    `UFDSM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_beat))

    // the stop bit is always a high line level
    `UFDSM_ASSERT_NOW(a_stop_high, i_clk, i_rst_n, o_out_valid && o_byte_valid, o_line_level)

    // no byte value outside the stop bit
    `UFDSM_ASSERT_NOW(a_byte_zero, i_clk, i_rst_n, o_out_valid && !o_byte_valid, o_byte_value == '0)

    // an empty output side never blocks input
    `UFDSM_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // a waiting input beat is seen by the block
    `UFDSM_ASSERT_NOW(a_in_seen, i_clk, i_rst_n, i_in_valid && !o_out_valid, o_in_ready)

endmodule

bind uart_framed_delta_sigma_modulator_top ufdsm_checker u_ufdsm_checker (.*);

/* bench/tb_uart_framed_delta_sigma_modulator_top.sv */
// ----------------------------------------------------------------------------
// tb_uart_framed_delta_sigma_modulator_top
// Drives bit-time beats of audio samples through the framed one-bit modulator
// and checks line level, sample latch, frame byte and byte flag of every
// result beat against a cycle-free model of the accumulator, quantizer and
// frame counter. Covers rail inputs, error saturation, zero and wrapping
// increments, random sender gaps, receiver stalls and one long back-pressure.
// ----------------------------------------------------------------------------
module tb_uart_framed_delta_sigma_modulator_top;

    localparam int SW = ufdsm_pkg::SAMPLE_W;
    localparam int PW = ufdsm_pkg::PHASE_W;
    localparam int BW = ufdsm_pkg::BYTE_W;
    localparam int EW = ufdsm_pkg::ERR_W;
    localparam int QW = ufdsm_pkg::POS_W;
    localparam int CW = ufdsm_pkg::ERR_CALC_W;

    localparam int FRAC_BITS    = ufdsm_pkg::PHASE_FRAC_BITS_DEF;
    localparam int LIMIT_CYCLES = 100000;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int LONG_HOLD    = 60;

    localparam logic signed [SW-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SW-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic [PW-1:0] INC_SLOWEST  = 32'd6710887;
    localparam logic [PW-1:0] INC_FROZEN   = 32'h0000_0000;
    localparam logic [PW-1:0] INC_WRAPPING = 32'hFFFF_FFFF;

    // kinds of sample streams offered by the source
    typedef enum int {
        SRC_NOISE,
        SRC_RAIL_HI,
        SRC_RAIL_LO,
        SRC_RAMP,
        SRC_QUIET
    } t_src_style;

    // one result beat
    typedef struct packed {
        logic          line_level;
        logic          sample_taken;
        logic          byte_valid;
        logic [BW-1:0] byte_value;
    } t_bit_time;

    // accumulator, quantizer and framer state plus the beats still owed
    class t_frame_predictor;
        logic [PW-1:0]         phase_inc;
        logic [PW-1:0]         phase_acc;
        logic signed [SW-1:0]  held;
        logic signed [EW-1:0]  fb_err;
        logic [QW-1:0]         pos;
        logic [BW-1:0]         shreg;
        t_bit_time             awaited_bits[$];
        int unsigned           mismatches;

        function new();
            phase_inc    = ufdsm_pkg::PHASE_INC_RESET;
            phase_acc    = PW'(1) << FRAC_BITS;
            held         = '0;
            fb_err       = '0;
            pos          = ufdsm_pkg::POS_START;
            shreg        = '0;
            mismatches   = 0;
        endfunction

        function void set_increment(input logic [PW-1:0] v);
            phase_inc = v;
        endfunction

        // work out the result of one accepted bit time
        function void note_bit_time(input logic signed [SW-1:0] s);
            logic [PW-1:0]        int_bit;
            logic signed [CW-1:0] want;
            logic signed [CW-1:0] nxt_err;
            t_bit_time            r;
            int_bit = PW'(1) << FRAC_BITS;
            r = '0;
            if ((phase_acc & int_bit) != '0) begin
                held = s;
                r.sample_taken = 1'b1;
            end
            phase_acc = (phase_acc & (int_bit - PW'(1))) + phase_inc;
            want = held - fb_err;

            // start bit low, stop bit high, data bits by the error sign
            if (pos == ufdsm_pkg::POS_START) begin
                r.line_level = 1'b0;
                shreg = '0;
                pos = ufdsm_pkg::POS_START + QW'(1);
            end else if (pos >= ufdsm_pkg::POS_STOP) begin
                r.line_level = 1'b1;
                r.byte_valid = 1'b1;
                r.byte_value = shreg;
                pos = ufdsm_pkg::POS_START;
            end else begin
                r.line_level = (want >= 0);
                shreg = {r.line_level, shreg[BW-1:1]};
                pos = pos + QW'(1);
            end

            // every bit, forced or chosen, feeds back its error
            nxt_err = (r.line_level ? ufdsm_pkg::LEVEL_HIGH : ufdsm_pkg::LEVEL_LOW) - want;
            if (nxt_err > ufdsm_pkg::ERR_MAX) nxt_err = ufdsm_pkg::ERR_MAX;
            if (nxt_err < ufdsm_pkg::ERR_MIN) nxt_err = ufdsm_pkg::ERR_MIN;
            fb_err = nxt_err[EW-1:0];
            awaited_bits.push_back(r);
        endfunction

        // compare one accepted result beat with the oldest owed one
        function void check_bit_time(input t_bit_time got);
            t_bit_time exp_bit;
            if (awaited_bits.size() == 0) begin
                $error("result beat with nothing owed: level %0d taken %0d byte %0d/%0h",
                       got.line_level, got.sample_taken, got.byte_valid, got.byte_value);
                mismatches++;
                return;
            end
            exp_bit = awaited_bits.pop_front();
            if (got.line_level !== exp_bit.line_level) begin
                $error("line_level: expected %0d, got %0d", exp_bit.line_level, got.line_level);
                mismatches++;
            end
            if (got.sample_taken !== exp_bit.sample_taken) begin
                $error("sample_taken: expected %0d, got %0d",
                       exp_bit.sample_taken, got.sample_taken);
                mismatches++;
            end
            if (got.byte_valid !== exp_bit.byte_valid) begin
                $error("byte_valid: expected %0d, got %0d", exp_bit.byte_valid, got.byte_valid);
                mismatches++;
            end
            if (got.byte_value !== exp_bit.byte_value) begin
                $error("byte_value: expected %02h, got %02h",
                       exp_bit.byte_value, got.byte_value);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic signed [SW-1:0] i_next_sample;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_line_level;
    logic                 o_sample_taken;
    logic                 o_byte_valid;
    logic [BW-1:0]        o_byte_value;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [PW-1:0]        i_cfg_phase_increment;

    t_frame_predictor predictor = new();

    int  burst_left    = 0;
    bit  steady        = 1'b0;
    bit  pressure_req  = 1'b0;
    bit  pressure_seen = 1'b0;
    int  cycle_count   = 0;

    uart_framed_delta_sigma_modulator_top #(
        .PHASE_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_next_sample         (i_next_sample),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_line_level          (o_line_level),
        .o_sample_taken        (o_sample_taken),
        .o_byte_valid          (o_byte_valid),
        .o_byte_value          (o_byte_value),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_phase_increment (i_cfg_phase_increment)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // result side: stall pattern of its own, one long hold on request
    initial begin
        int mode;
        int span;
        int hold;
        int phase_cnt;
        mode = 0;
        span = 0;
        hold = 0;
        phase_cnt = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            phase_cnt++;
            if (pressure_req && !pressure_seen) begin
                pressure_seen = 1'b1;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(10, 120);
                end
                span--;
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= ((phase_cnt % 5) < 3);
                    default: i_out_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // result beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            predictor.check_bit_time('{o_line_level, o_sample_taken, o_byte_valid,
                                       o_byte_value});
        end
    end

    // offer one sample beat, with random gaps between bursts
    task automatic send_sample(input logic signed [SW-1:0] s);
        if (!steady && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid    <= 1'b1;
        i_next_sample <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predictor.note_bit_time(s);
        @(negedge i_clk);
    endtask

    // one stretch of source samples of a given kind
    task automatic send_segment(input t_src_style style, input int len);
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] step;
        s    = SW'($urandom);
        step = SW'($urandom_range(0, 4095) - 2048);
        repeat (len) begin
            case (style)
                SRC_NOISE:   s = SW'($urandom);
                SRC_RAIL_HI: s = SAMPLE_MAX;
                SRC_RAIL_LO: s = SAMPLE_MIN;
                SRC_RAMP:    s = s + step;
                default:     s = SW'($urandom_range(0, 63) - 32);
            endcase
            send_sample(s);
        end
    endtask

    // wait until every owed beat is back and the pipe has settled
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (predictor.awaited_bits.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // write the increment register while idle
    task automatic write_increment(input logic [PW-1:0] v);
        wait_idle();
        i_cfg_valid           <= 1'b1;
        i_cfg_phase_increment <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        predictor.set_increment(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random mix of source stretches
    task automatic run_mix(input int n_items);
        int         sent;
        int         len;
        t_src_style style;
        sent = 0;
        while (sent < n_items) begin
            style = t_src_style'($urandom_range(0, 4));
            len   = $urandom_range(5, 30);
            if (len > n_items - sent) len = n_items - sent;
            send_segment(style, len);
            sent += len;
        end
    endtask

    // main sequence
    initial begin
        logic signed [SW-1:0] corner [20];
        corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
                   16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h4000,
                   16'hC000, 16'h7FFE, 16'h8001, 16'h0002, 16'hFFFE,
                   16'h0064, 16'hFF9C, 16'h1234, 16'hEDCB, 16'h0000};
        i_rst_n               = 1'b0;
        i_in_valid            = 1'b0;
        i_next_sample         = '0;
        i_cfg_valid           = 1'b0;
        i_cfg_phase_increment = '0;

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner samples at the reset rate, two full frames
        write_increment(ufdsm_pkg::PHASE_INC_RESET);
        foreach (corner[k]) send_sample(corner[k]);

        // long rail runs drive the feedback error into saturation both ways
        send_segment(SRC_RAIL_HI, 85);
        send_segment(SRC_RAIL_LO, 85);
        run_mix(20);

        // slowest sample rate
        write_increment(INC_SLOWEST);
        run_mix(40);

        // frozen accumulator keeps the held sample
        write_increment(INC_FROZEN);
        run_mix(30);

        // accumulator sum wraps
        write_increment(INC_WRAPPING);
        run_mix(40);

        // random legal rate, then a long receiver hold with the sender busy
        write_increment($urandom_range(INC_SLOWEST, ufdsm_pkg::PHASE_INC_RESET));
        run_mix(40);
        steady       = 1'b1;
        pressure_req = 1'b1;
        send_segment(SRC_NOISE, 70);
        steady       = 1'b0;

        // any 32-bit increment
        write_increment($urandom);
        run_mix(40);

        // back to the fastest legal rate
        write_increment(ufdsm_pkg::PHASE_INC_RESET);
        run_mix(20);

        // drain and report
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (predictor.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
